// ===== rtl/actc_pkg.sv =====
// Shared types, constants and the display width table of the ANSI-aware text clipper.
package actc_pkg;

  // Default column counter width and the reset column budget.
  localparam int COLUMN_BITS_DEF = 10;
  localparam int RESET_BUDGET    = 80;

  // Most bytes that one input byte can release.
  localparam int MAX_OUT = 4;

  // Escape tracking modes.
  localparam logic [2:0] ESC_PLAIN   = 3'd0;
  localparam logic [2:0] ESC_AFTER   = 3'd1;
  localparam logic [2:0] ESC_CSI     = 3'd2;
  localparam logic [2:0] ESC_OSC     = 3'd3;
  localparam logic [2:0] ESC_OSC_ESC = 3'd4;

  // Byte codes of interest.
  localparam logic [7:0] BYTE_ESC  = 8'h1B;
  localparam logic [7:0] BYTE_BEL  = 8'h07;
  localparam logic [7:0] BYTE_LBRK = 8'h5B;
  localparam logic [7:0] BYTE_RBRK = 8'h5D;
  localparam logic [7:0] BYTE_BSL  = 8'h5C;

  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_MAX         = 21'h10FFFF;

  // One queue entry: the bytes kept for one input byte.
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [2:0]              cnt;
    logic                    last;
  } entry_t;

  // Display width of a codepoint: 0, 1 or 2 columns.
  function automatic logic [1:0] cp_columns(logic [20:0] c);
    logic [1:0] w;
    w = 2'd1;
    if (c < 21'h20 || (c >= 21'h7F && c < 21'hA0)) begin
      w = 2'd0;
    end else if ((c >= 21'h0300 && c <= 21'h036F) || (c >= 21'h1AB0 && c <= 21'h1AFF) ||
                 (c >= 21'h1DC0 && c <= 21'h1DFF) || (c >= 21'h20D0 && c <= 21'h20FF) ||
                 (c >= 21'hFE00 && c <= 21'hFE0F) || (c >= 21'hFE20 && c <= 21'hFE2F) ||
                 (c >= 21'h200B && c <= 21'h200F) || c == 21'h2060 || c == 21'hFEFF) begin
      w = 2'd0;
    end else if ((c >= 21'h1100 && c <= 21'h115F) || (c >= 21'h2E80 && c <= 21'h303E) ||
                 (c >= 21'h3041 && c <= 21'h33FF) || (c >= 21'h3400 && c <= 21'h4DBF) ||
                 (c >= 21'h4E00 && c <= 21'h9FFF) || (c >= 21'hA000 && c <= 21'hA4CF) ||
                 (c >= 21'hA960 && c <= 21'hA97F) || (c >= 21'hAC00 && c <= 21'hD7A3) ||
                 (c >= 21'hF900 && c <= 21'hFAFF) || (c >= 21'hFE30 && c <= 21'hFE4F) ||
                 (c >= 21'hFF00 && c <= 21'hFF60) || (c >= 21'hFFE0 && c <= 21'hFFE6) ||
                 (c >= 21'h20000 && c <= 21'h2FFFD) ||
                 (c >= 21'h30000 && c <= 21'h3FFFD)) begin
      w = 2'd2;
    end
    return w;
  endfunction

endpackage

// ===== rtl/actc_front.sv =====
// Front end: decodes UTF-8 and escapes, applies the column budget, queues kept bytes.
module actc_front #(
  parameter int COLUMN_BITS = actc_pkg::COLUMN_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             in_byte,
  input  logic                   in_text_last,
  input  logic [COLUMN_BITS-1:0] max_cols,
  output logic                   push,
  output actc_pkg::entry_t       entry
);

  typedef struct packed {
    logic [COLUMN_BITS-1:0] cu;
    logic                   full;
    logic                   keep;
  } bud_t;

  // One unit against the budget: returns the new budget state and whether it is kept.
  function automatic bud_t put_unit(bud_t s, logic [1:0] w, logic [COLUMN_BITS-1:0] mx);
    bud_t r;
    logic [COLUMN_BITS:0] sum;
    r = s;
    r.keep = 1'b0;
    sum = {1'b0, s.cu} + {{(COLUMN_BITS-1){1'b0}}, w};
    if (!s.full) begin
      if (w != 2'd0 && sum > {1'b0, mx}) begin
        r.full = 1'b1;
      end else begin
        if (w != 2'd0) r.cu = sum[COLUMN_BITS-1:0];
        r.keep = 1'b1;
      end
    end
    return r;
  endfunction

  logic [COLUMN_BITS-1:0] cu_r, cu_nxt;
  logic                   full_r, full_nxt;
  logic [2:0]             esc_r, esc_nxt;
  logic [1:0]             pc_r, pc_nxt;
  logic [2:0]             sl_r, sl_nxt;
  logic [7:0]             pb_r [0:2];
  logic [7:0]             pb_nxt [0:2];

  logic [7:0]  ob [0:3];
  logic [2:0]  oc;
  bud_t        bs;
  logic        do_plain;
  logic        cont;
  logic [20:0] cp;
  logic        bad;
  logic        en;

  // Per-byte state update and collection of kept bytes.
  always_comb begin
    bs       = '{cu: cu_r, full: full_r, keep: 1'b0};
    esc_nxt  = esc_r;
    pc_nxt   = pc_r;
    sl_nxt   = sl_r;
    pb_nxt   = pb_r;
    oc       = 3'd0;
    do_plain = 1'b0;
    cont     = (in_byte[7:6] == 2'b10);
    cp       = '0;
    bad      = 1'b0;
    en       = (max_cols != '0);
    for (int k = 0; k < 4; k++) ob[k] = 8'h00;

    if (esc_r != actc_pkg::ESC_PLAIN) begin
      // Escape bytes pass whenever the budget is not zero.
      if (en) begin ob[oc[1:0]] = in_byte; oc = oc + 3'd1; end
      unique case (esc_r)
        actc_pkg::ESC_AFTER: begin
          esc_nxt = (in_byte == actc_pkg::BYTE_LBRK) ? actc_pkg::ESC_CSI :
                    (in_byte == actc_pkg::BYTE_RBRK) ? actc_pkg::ESC_OSC :
                    actc_pkg::ESC_PLAIN;
        end
        actc_pkg::ESC_CSI: begin
          if (in_byte >= 8'h40 && in_byte <= 8'h7E) esc_nxt = actc_pkg::ESC_PLAIN;
        end
        actc_pkg::ESC_OSC_ESC: begin
          esc_nxt = (in_byte == actc_pkg::BYTE_BSL) ? actc_pkg::ESC_PLAIN :
                    (in_byte == actc_pkg::BYTE_BEL) ? actc_pkg::ESC_PLAIN :
                    (in_byte == actc_pkg::BYTE_ESC) ? actc_pkg::ESC_OSC_ESC :
                    actc_pkg::ESC_OSC;
        end
        default: begin
          esc_nxt = (in_byte == actc_pkg::BYTE_BEL) ? actc_pkg::ESC_PLAIN :
                    (in_byte == actc_pkg::BYTE_ESC) ? actc_pkg::ESC_OSC_ESC :
                    actc_pkg::ESC_OSC;
        end
      endcase
    end else begin
      do_plain = 1'b1;
      if (pc_r != 2'd0) begin
        if (cont) begin
          do_plain = 1'b0;
          if ({1'b0, pc_r} + 3'd1 >= sl_r) begin
            // Sequence complete: decode, validate and measure.
            case (sl_r)
              3'd2:    cp = {10'd0, pb_r[0][4:0], in_byte[5:0]};
              3'd3:    cp = {5'd0, pb_r[0][3:0], pb_r[1][5:0], in_byte[5:0]};
              default: cp = {pb_r[0][2:0], pb_r[1][5:0], pb_r[2][5:0], in_byte[5:0]};
            endcase
            bad = (sl_r == 3'd2 && cp < 21'h80) || (sl_r == 3'd3 && cp < 21'h800) ||
                  (sl_r == 3'd4 && cp < 21'h10000) || cp > actc_pkg::CP_MAX ||
                  (cp >= 21'hD800 && cp <= 21'hDFFF);
            if (bad) cp = actc_pkg::CP_REPLACEMENT;
            bs = put_unit(bs, actc_pkg::cp_columns(cp), max_cols);
            if (bs.keep && en) begin
              for (int k = 0; k < 4; k++) begin
                if (k < pc_r) begin
                  ob[k] = pb_r[k];
                end else if (k == pc_r) begin
                  ob[k] = in_byte;
                end
              end
              oc = {1'b0, pc_r} + 3'd1;
            end
            pc_nxt = 2'd0;
            sl_nxt = 3'd0;
          end else begin
            case (pc_r)
              2'd1:    pb_nxt[1] = in_byte;
              default: pb_nxt[2] = in_byte;
            endcase
            pc_nxt = pc_r + 2'd1;
          end
        end else begin
          // Broken sequence: every held byte becomes its own unit.
          for (int k = 0; k < 3; k++) begin
            if (k < pc_r) begin
              bs = put_unit(bs, 2'd1, max_cols);
              if (bs.keep && en) begin ob[oc[1:0]] = pb_r[k]; oc = oc + 3'd1; end
            end
          end
          pc_nxt = 2'd0;
          sl_nxt = 3'd0;
        end
      end
      if (do_plain) begin
        if (in_byte == actc_pkg::BYTE_ESC) begin
          esc_nxt = actc_pkg::ESC_AFTER;
          if (en) begin ob[oc[1:0]] = in_byte; oc = oc + 3'd1; end
        end else if (!in_byte[7]) begin
          bs = put_unit(bs, actc_pkg::cp_columns({13'd0, in_byte}), max_cols);
          if (bs.keep && en) begin ob[oc[1:0]] = in_byte; oc = oc + 3'd1; end
        end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110 ||
                     in_byte[7:3] == 5'b11110) begin
          pb_nxt[0] = in_byte;
          pc_nxt    = 2'd1;
          sl_nxt    = (in_byte[7:5] == 3'b110) ? 3'd2 :
                      (in_byte[7:4] == 4'b1110) ? 3'd3 : 3'd4;
        end else begin
          bs = put_unit(bs, 2'd1, max_cols);
          if (bs.keep && en) begin ob[oc[1:0]] = in_byte; oc = oc + 3'd1; end
        end
      end
    end

    // End of text: flush a truncated sequence and return to the start state.
    if (in_text_last) begin
      for (int k = 0; k < 3; k++) begin
        if (k < pc_nxt) begin
          bs = put_unit(bs, 2'd1, max_cols);
          if (bs.keep && en) begin ob[oc[1:0]] = pb_nxt[k]; oc = oc + 3'd1; end
        end
      end
      pc_nxt  = 2'd0;
      sl_nxt  = 3'd0;
      bs.cu   = '0;
      bs.full = 1'b0;
      esc_nxt = actc_pkg::ESC_PLAIN;
    end

    cu_nxt   = bs.cu;
    full_nxt = bs.full;
  end

  // Queue entry for the back end.
  always_comb begin
    for (int k = 0; k < 4; k++) entry.bytes[k] = ob[k];
    entry.cnt  = oc;
    entry.last = in_text_last;
    push       = accept && (oc != 3'd0 || in_text_last);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cu_r   <= '0;
      full_r <= 1'b0;
      esc_r  <= actc_pkg::ESC_PLAIN;
      pc_r   <= 2'd0;
      sl_r   <= 3'd0;
    end else if (accept) begin
      cu_r   <= cu_nxt;
      full_r <= full_nxt;
      esc_r  <= esc_nxt;
      pc_r   <= pc_nxt;
      sl_r   <= sl_nxt;
    end
  end

  // Held sequence bytes need no reset.
  always_ff @(posedge clk) begin
    if (accept) pb_r <= pb_nxt;
  end

endmodule

// ===== rtl/actc_fifo.sv =====
// Two-entry queue between the front end and the back end.
module actc_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  actc_pkg::entry_t wr_entry,
  input  logic             pop,
  output actc_pkg::entry_t rd_entry,
  output logic             full,
  output logic             empty
);

  actc_pkg::entry_t mem_r [0:1];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign rd_entry = mem_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_entry;
  end

endmodule

// ===== rtl/actc_back.sv =====
// Back end: splits each queue entry into output transactions behind an output register.
module actc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  actc_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_run_last,
  output logic             out_text_end
);

  logic [1:0] beat_r;
  logic       ov_r;
  logic [7:0] ob_r;
  logic       bv_r, rl_r, te_r;
  logic       load;
  logic [2:0] nbeats;
  logic       last_beat;

  // A bare end marker is one beat.
  assign load      = !ov_r || !out_stall;
  assign nbeats    = (head.cnt == 3'd0) ? 3'd1 : head.cnt;
  assign last_beat = ({1'b0, beat_r} == nbeats - 3'd1);
  assign pop       = load && !empty && last_beat;

  // Beat counter within the head entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= 2'd0;
      ov_r   <= 1'b0;
    end else if (load) begin
      ov_r <= !empty;
      if (!empty) beat_r <= last_beat ? 2'd0 : beat_r + 2'd1;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load && !empty) begin
      ob_r <= (head.cnt == 3'd0) ? 8'h00 : head.bytes[beat_r];
      bv_r <= (head.cnt != 3'd0);
      rl_r <= last_beat;
      te_r <= last_beat && head.last;
    end
  end

  assign out_valid      = ov_r;
  assign out_byte       = ob_r;
  assign out_byte_valid = bv_r;
  assign out_run_last   = rl_r;
  assign out_text_end   = te_r;

endmodule

// ===== rtl/ansi_aware_text_clipper_core.sv =====
// Top level of the ANSI-aware text clipper: front end, queue, back end and budget register.
//
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | in_byte, in_text_last
// out_    | output    | out_valid/out_stall| out_byte, out_byte_valid, out_run_last, out_text_end
// cfg_    | input     | cfg_valid/cfg_ready| cfg_max_columns
//
// One input byte is taken per cycle while the two-entry queue has room.
// An input byte that keeps n bytes (up to four) becomes n output transactions,
// so a burst of multi-byte results holds the input back while the queue is full.
// An accepted input transaction passes the queue and then the output register
// before out_valid rises for its first result; out_stall can hold it back.
// Synchronous active-low reset clears all control state and sets the budget to 80.
// cfg_ready is always high.
module ansi_aware_text_clipper_core #(
  parameter int COLUMN_BITS = actc_pkg::COLUMN_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_byte,
  input  logic                   in_text_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_byte_valid,
  output logic                   out_run_last,
  output logic                   out_text_end,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COLUMN_BITS-1:0] cfg_max_columns
);

  localparam logic [COLUMN_BITS-1:0] BUDGET_RST = COLUMN_BITS'(actc_pkg::RESET_BUDGET);

  logic [COLUMN_BITS-1:0] max_cols_r;
  logic                   accept;
  logic                   fifo_push, fifo_pop, fifo_full, fifo_empty;
  actc_pkg::entry_t       wr_entry, rd_entry;

  assign in_stall  = fifo_full;
  assign accept    = in_valid && !fifo_full;
  assign cfg_ready = 1'b1;

  // Column budget register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cols_r <= BUDGET_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_cols_r <= cfg_max_columns;
    end
  end

  actc_front #(.COLUMN_BITS(COLUMN_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_text_last (in_text_last),
    .max_cols     (max_cols_r),
    .push         (fifo_push),
    .entry        (wr_entry)
  );

  actc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .wr_entry (wr_entry),
    .pop      (fifo_pop),
    .rd_entry (rd_entry),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  actc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (rd_entry),
    .empty          (fifo_empty),
    .pop            (fifo_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_text_end   (out_text_end)
  );

  // A bare end marker always closes both the run and the text.
  a_marker_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_text_end && out_run_last)
    else $error("end marker without end flags");

  // The end of a text is always the last result of its input byte.
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_end |-> out_run_last)
    else $error("text end not on last result of run");

  // The queue is never written while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_full)
    else $error("queue overflow");

  // An entry is only retired when one is present.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_empty)
    else $error("queue underflow");

endmodule
